/* rtl/rse_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_pkg
// Shared constants, register codes and types of the Reed-Solomon encoder.
// ----------------------------------------------------------------------------
package rse_pkg;

    localparam int SYM_W         = 5;
    localparam int POLY_W        = SYM_W + 1;
    localparam int COEF_REG_W    = 40;
    localparam int COEFS_PER_REG = 8;
    localparam int COEF_COUNT    = 2 * COEFS_PER_REG;
    localparam int POS_W         = 5;
    localparam int COUNT_W       = 4;
    localparam int CODE_LEN      = 30;
    localparam int MSG_LEN       = 14;
    localparam int PARITY_COUNT  = 16;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_POLY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GEN_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GEN_HIGH   = 2'd2;

    localparam logic [POLY_W-1:0]     FIELD_POLY_RST = 6'd37;
    localparam logic [COEF_REG_W-1:0] GEN_LOW_RST    = 40'd704908874862;
    localparam logic [COEF_REG_W-1:0] GEN_HIGH_RST   = 40'd545508297497;

    typedef struct packed {
        logic step;   // absorb one message symbol
        logic shift;  // move parity down by one, top fills with zero
    } t_lfsr_ctl;

endpackage

/* rtl/rse_gf_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_gf_mul
// GF(2^m) multiplier, shift-and-add with reduction by the field polynomial.
// ----------------------------------------------------------------------------
module rse_gf_mul (
    input  logic [rse_pkg::SYM_W-1:0]  i_a,
    input  logic [rse_pkg::SYM_W-1:0]  i_b,
    input  logic [rse_pkg::POLY_W-1:0] i_poly,
    output logic [rse_pkg::SYM_W-1:0]  o_p
);

    always_comb begin
        logic [rse_pkg::SYM_W-1:0] acc;
        logic [rse_pkg::SYM_W-1:0] a;
        logic [rse_pkg::SYM_W:0]   t;
        acc = '0;
        a   = i_a;
        for (int i = 0; i < rse_pkg::SYM_W; i++) begin
            if (i_b[i]) begin
                acc = acc ^ a;
            end
            t = {a, 1'b0};
            if (t[rse_pkg::SYM_W]) begin
                t = t ^ i_poly;
            end
            a = t[rse_pkg::SYM_W-1:0];
        end
        o_p = acc;
    end

endmodule

/* rtl/rse_lfsr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_lfsr
// Division LFSR holding the parity symbols; also shifts them out after a block.
// ----------------------------------------------------------------------------
module rse_lfsr #(
    parameter int PARITY_COUNT = rse_pkg::PARITY_COUNT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rse_pkg::t_lfsr_ctl             i_ctl,
    input  logic [rse_pkg::SYM_W-1:0]      i_symbol,
    input  logic [rse_pkg::POLY_W-1:0]     i_field_poly,
    input  logic [rse_pkg::COEF_REG_W-1:0] i_gen_low,
    input  logic [rse_pkg::COEF_REG_W-1:0] i_gen_high,
    output logic [rse_pkg::SYM_W-1:0]      o_parity_low
);

    logic [rse_pkg::SYM_W-1:0] r_par [PARITY_COUNT];
    logic [rse_pkg::SYM_W-1:0] n_par [PARITY_COUNT];
    logic [rse_pkg::SYM_W-1:0] coef  [PARITY_COUNT];
    logic [rse_pkg::SYM_W-1:0] prod  [PARITY_COUNT];
    logic [rse_pkg::SYM_W-1:0] fb;

    assign fb = i_symbol ^ r_par[PARITY_COUNT-1];

    for (genvar k = 0; k < PARITY_COUNT; k++) begin : g_tap
        localparam int SLOT = k % rse_pkg::COEFS_PER_REG;
        if (k < rse_pkg::COEFS_PER_REG) begin : g_low
            assign coef[k] = i_gen_low[SLOT*rse_pkg::SYM_W +: rse_pkg::SYM_W];
        end else if (k < rse_pkg::COEF_COUNT) begin : g_high
            assign coef[k] = i_gen_high[SLOT*rse_pkg::SYM_W +: rse_pkg::SYM_W];
        end else begin : g_none
            assign coef[k] = '0;
        end

        rse_gf_mul u_mul (
            .i_a    (coef[k]),
            .i_b    (fb),
            .i_poly (i_field_poly),
            .o_p    (prod[k])
        );
    end

    always_comb begin
        for (int k = 0; k < PARITY_COUNT; k++) begin
            n_par[k] = r_par[k];
            if (i_ctl.step) begin
                n_par[k] = (k == 0) ? prod[k] : (r_par[(k == 0) ? 0 : k-1] ^ prod[k]);
            end else if (i_ctl.shift) begin
                n_par[k] = (k == PARITY_COUNT-1) ? '0
                         : r_par[(k == PARITY_COUNT-1) ? k : k+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PARITY_COUNT; k++) begin
                r_par[k] <= '0;
            end
        end else begin
            for (int k = 0; k < PARITY_COUNT; k++) begin
                r_par[k] <= n_par[k];
            end
        end
    end

    assign o_parity_low = r_par[0];

endmodule

/* rtl/reed_solomon_systematic_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reed_solomon_systematic_encoder
// Systematic RS encoder over GF(2^5): echoes message symbols, then parity.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries message symbols, highest degree first; tlast marks
//   the final symbol of a block. Master stream carries the codeword: each
//   message symbol echoed with its position, tuser = 0, then PARITY_COUNT
//   parity symbols at positions 0..PARITY_COUNT-1 with tuser = 1, the last
//   one with tlast = 1.
//   A symbol appears on the master side in the cycle after its transaction.
//   Throughput: one message symbol per cycle unless back-pressure or parity
//   output holds the slave side; all parity taps update in the same cycle
//   through one GF multiplier each. After a tlast transaction the slave side
//   is held off while parity shifts out, one symbol per master transaction.
//   A single output register separates the sides; slave tready follows
//   master tready when that register is full, so a stall holds both.
//   Configuration writes (field polynomial, generator coefficients) through
//   the write port must be made while idle; the block does not enforce this.
//   Reset clears the parity register, the symbol counter and the output
//   register, and loads the default field polynomial and generator.
// ----------------------------------------------------------------------------
module reed_solomon_systematic_encoder #(
    parameter int PARITY_COUNT = rse_pkg::PARITY_COUNT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [rse_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rse_pkg::COEF_REG_W-1:0]    i_cfg_data,
    // slave stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [7:0]                        i_s_tdata,   // [4:0] msg_symbol
    input  logic                              i_s_tlast,   // msg_last
    // master stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [15:0]                       o_m_tdata,   // [4:0] code_symbol,
                                                           // [9:5] code_position
    output logic                              o_m_tuser,   // is_parity
    output logic                              o_m_tlast    // block_end
);

    localparam int CNT_W = $clog2(PARITY_COUNT);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PARITY_COUNT - 1);
    localparam logic [rse_pkg::COUNT_W-1:0] COUNT_MAX = rse_pkg::COUNT_W'(rse_pkg::MSG_LEN - 1);
    localparam logic [rse_pkg::POS_W-1:0] POS_TOP = rse_pkg::POS_W'(rse_pkg::CODE_LEN - 1);

    logic [rse_pkg::POLY_W-1:0]     r_field_poly;
    logic [rse_pkg::COEF_REG_W-1:0] r_gen_low;
    logic [rse_pkg::COEF_REG_W-1:0] r_gen_high;

    logic                         r_flush;
    logic [CNT_W-1:0]             r_flush_cnt;
    logic [rse_pkg::COUNT_W-1:0]  r_count;

    logic                         r_m_valid;
    logic [rse_pkg::SYM_W-1:0]    r_m_sym;
    logic [rse_pkg::POS_W-1:0]    r_m_pos;
    logic                         r_m_par;
    logic                         r_m_end;

    logic                         load_en;
    logic                         s_accept;
    logic                         flush_load;
    logic [rse_pkg::SYM_W-1:0]    msg_sym;
    logic [rse_pkg::SYM_W-1:0]    parity_low;
    rse_pkg::t_lfsr_ctl           lfsr_ctl;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_poly <= rse_pkg::FIELD_POLY_RST;
            r_gen_low    <= rse_pkg::GEN_LOW_RST;
            r_gen_high   <= rse_pkg::GEN_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rse_pkg::CFG_FIELD_POLY: r_field_poly <= i_cfg_data[rse_pkg::POLY_W-1:0];
                rse_pkg::CFG_GEN_LOW:    r_gen_low    <= i_cfg_data;
                rse_pkg::CFG_GEN_HIGH:   r_gen_high   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign msg_sym    = i_s_tdata[rse_pkg::SYM_W-1:0];
    assign load_en    = !r_m_valid || i_m_tready;
    assign o_s_tready = !r_flush && load_en;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign flush_load = r_flush && load_en;

    assign lfsr_ctl.step  = s_accept;
    assign lfsr_ctl.shift = flush_load;

    rse_lfsr #(
        .PARITY_COUNT (PARITY_COUNT)
    ) u_lfsr (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (lfsr_ctl),
        .i_symbol     (msg_sym),
        .i_field_poly (r_field_poly),
        .i_gen_low    (r_gen_low),
        .i_gen_high   (r_gen_high),
        .o_parity_low (parity_low)
    );

    // block control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flush     <= 1'b0;
            r_flush_cnt <= '0;
            r_count     <= '0;
        end else if (s_accept) begin
            if (i_s_tlast) begin
                r_flush     <= 1'b1;
                r_flush_cnt <= '0;
                r_count     <= '0;
            end else if (r_count < COUNT_MAX) begin
                r_count <= r_count + 1'b1;
            end
        end else if (flush_load) begin
            r_flush_cnt <= r_flush_cnt + 1'b1;
            if (r_flush_cnt == CNT_LAST) begin
                r_flush <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load_en) begin
            r_m_valid <= s_accept || flush_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_m_sym <= msg_sym;
            r_m_pos <= POS_TOP - rse_pkg::POS_W'(r_count);
            r_m_par <= 1'b0;
            r_m_end <= 1'b0;
        end else if (flush_load) begin
            r_m_sym <= parity_low;
            r_m_pos <= rse_pkg::POS_W'(r_flush_cnt);
            r_m_par <= 1'b1;
            r_m_end <= (r_flush_cnt == CNT_LAST);
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {6'd0, r_m_pos, r_m_sym};
    assign o_m_tuser  = r_m_par;
    assign o_m_tlast  = r_m_end;

    a_no_accept_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> !o_s_tready)
        else $error("input taken while parity shifts out");

    a_last_starts_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_tlast) |=> (r_flush && o_m_tvalid && !o_m_tuser))
        else $error("final symbol did not start parity output");

    a_end_is_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tuser && r_m_pos == rse_pkg::POS_W'(PARITY_COUNT - 1)))
        else $error("block end not on the last parity symbol");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled result changed");

endmodule

/* tb/sv/reed_solomon_systematic_encoder_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reed_solomon_systematic_encoder_test
// Self-checking bench for the systematic Reed-Solomon encoder. Message symbols
// go in through the slave stream and are run through a software LFSR encoder;
// every codeword symbol on the master stream is checked in order against it.
// Field polynomial and generator are rewritten between idle phases, random
// back-pressure and source gaps are applied on both streams.
// ----------------------------------------------------------------------------
module reed_solomon_systematic_encoder_test;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 7;
    localparam int IDLE_PCT     = 34;
    localparam int CALM_FROM    = 70;
    localparam int CALM_TO      = 110;
    localparam int HOLD_AT      = 60;
    localparam int HOLD_CYCLES  = 50;
    localparam int DRAIN_CYCLES = 4;
    localparam int LIMIT_CYCLES = 200000;

    localparam logic [rse_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [rse_pkg::SYM_W-1:0] sym;
        logic                      last;
        logic                      pause;  // hold until all codeword symbols are out
    } t_msg;

    typedef struct packed {
        logic [rse_pkg::SYM_W-1:0] sym;
        logic [rse_pkg::POS_W-1:0] pos;
        logic                      parity;
        logic                      closes;
    } t_code;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [rse_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rse_pkg::COEF_REG_W-1:0] cfg_data = '0;
    logic                           s_tvalid = 1'b0;
    logic [7:0]                     s_tdata = '0;
    logic                           s_tlast = 1'b0;
    logic                           m_tready = 1'b0;
    logic                           o_s_tready;
    logic                           o_m_tvalid;
    logic [15:0]                    o_m_tdata;
    logic                           o_m_tuser;
    logic                           o_m_tlast;

    reed_solomon_systematic_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // encoder model state
    logic [rse_pkg::POLY_W-1:0]     poly_cfg = rse_pkg::FIELD_POLY_RST;
    logic [rse_pkg::COEF_REG_W-1:0] gen_low_cfg = rse_pkg::GEN_LOW_RST;
    logic [rse_pkg::COEF_REG_W-1:0] gen_high_cfg = rse_pkg::GEN_HIGH_RST;
    logic [rse_pkg::SYM_W-1:0]      parity_sr [rse_pkg::PARITY_COUNT];
    logic [rse_pkg::COUNT_W-1:0]    msg_count = '0;

    t_msg  msg_queue [$];
    t_code expected_code [$];
    t_msg  cur_msg;
    int    msgs_taken = 0;
    int    codes_seen = 0;
    int    hold_left = 0;
    int    mismatches = 0;
    int    cycles = 0;
    logic  calm;

    assign calm = (msgs_taken >= CALM_FROM) && (msgs_taken < CALM_TO);

    initial begin
        for (int k = 0; k < rse_pkg::PARITY_COUNT; k++) parity_sr[k] = '0;
    end

    function automatic logic [rse_pkg::SYM_W-1:0] gf_times(logic [rse_pkg::SYM_W-1:0] a_in,
                                                           logic [rse_pkg::SYM_W-1:0] b);
        logic [rse_pkg::POLY_W-1:0] a;
        logic [rse_pkg::SYM_W-1:0]  r;
        a = {1'b0, a_in};
        r = '0;
        for (int i = 0; i < rse_pkg::SYM_W; i++) begin
            if (b[i]) r = r ^ a[rse_pkg::SYM_W-1:0];
            a = {a[rse_pkg::SYM_W-1:0], 1'b0};
            if (a[rse_pkg::SYM_W]) a = a ^ poly_cfg;
            a[rse_pkg::SYM_W] = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [rse_pkg::SYM_W-1:0] gen_tap(int k);
        if (k < rse_pkg::COEFS_PER_REG) return gen_low_cfg[k*rse_pkg::SYM_W +: rse_pkg::SYM_W];
        return gen_high_cfg[(k-rse_pkg::COEFS_PER_REG)*rse_pkg::SYM_W +: rse_pkg::SYM_W];
    endfunction

    // LFSR division step plus the codeword symbols it releases
    function automatic void absorb_symbol(logic [rse_pkg::SYM_W-1:0] sym, logic last);
        logic [rse_pkg::SYM_W-1:0] fb;
        t_code                     c;
        fb = sym ^ parity_sr[rse_pkg::PARITY_COUNT-1];
        for (int k = rse_pkg::PARITY_COUNT - 1; k >= 1; k--)
            parity_sr[k] = parity_sr[k-1] ^ gf_times(gen_tap(k), fb);
        parity_sr[0] = gf_times(gen_tap(0), fb);
        c.sym    = sym;
        c.pos    = rse_pkg::POS_W'(rse_pkg::CODE_LEN - 1 - int'(msg_count));
        c.parity = 1'b0;
        c.closes = 1'b0;
        expected_code.push_back(c);
        if (!last) begin
            if (msg_count < rse_pkg::COUNT_W'(rse_pkg::MSG_LEN - 1)) msg_count++;
        end else begin
            for (int k = 0; k < rse_pkg::PARITY_COUNT; k++) begin
                c.sym    = parity_sr[k];
                c.pos    = rse_pkg::POS_W'(k);
                c.parity = 1'b1;
                c.closes = (k == rse_pkg::PARITY_COUNT - 1);
                expected_code.push_back(c);
                parity_sr[k] = '0;
            end
            msg_count = '0;
        end
    endfunction

    function automatic void report_field(string name, int want, int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
    endfunction

    // source side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                absorb_symbol(cur_msg.sym, cur_msg.last);
                msgs_taken++;
            end
            if (s_tvalid && !o_s_tready) begin
                // transaction still pending, hold
            end else if (msg_queue.size() > 0
                         && !(msg_queue[0].pause && expected_code.size() > 0)
                         && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                cur_msg = msg_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {3'b000, cur_msg.sym};
                s_tlast  <= cur_msg.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // sink side
    always @(posedge i_clk) begin
        t_code want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                codes_seen++;
                if (expected_code.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none, actual sym %0d pos %0d",
                             $time, o_m_tdata[4:0], o_m_tdata[9:5]);
                    mismatches++;
                end else begin
                    want = expected_code.pop_front();
                    if (o_m_tdata[4:0] !== want.sym)
                        report_field("code_symbol", int'(want.sym), int'(o_m_tdata[4:0]));
                    if (o_m_tdata[9:5] !== want.pos)
                        report_field("code_position", int'(want.pos), int'(o_m_tdata[9:5]));
                    if (o_m_tuser !== want.parity)
                        report_field("is_parity", int'(want.parity), int'(o_m_tuser));
                    if (o_m_tlast !== want.closes)
                        report_field("block_end", int'(want.closes), int'(o_m_tlast));
                end
                if (codes_seen == HOLD_AT) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == LIMIT_CYCLES) begin
            $display("reed_solomon_systematic_encoder_test failed");
            $finish;
        end
    end

    function automatic void push_symbol(logic [rse_pkg::SYM_W-1:0] sym, logic last,
                                        logic pause);
        t_msg m;
        m.sym   = sym;
        m.last  = last;
        m.pause = pause;
        msg_queue.push_back(m);
    endfunction

    // random blocks, mostly legal length, some overlong
    function automatic void add_blocks(int n_items, logic pause_first);
        int len;
        int added;
        added = 0;
        while (added < n_items) begin
            len = ($urandom_range(9) < 2) ? $urandom_range(20, rse_pkg::MSG_LEN + 1)
                                          : $urandom_range(rse_pkg::MSG_LEN, 1);
            for (int i = 0; i < len; i++)
                push_symbol(rse_pkg::SYM_W'($urandom), i == len - 1,
                            pause_first && added == 0 && i == 0);
            added += len;
        end
    endfunction

    task automatic write_reg(logic [rse_pkg::CFG_IDX_W-1:0] idx,
                             logic [rse_pkg::COEF_REG_W-1:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            rse_pkg::CFG_FIELD_POLY: poly_cfg = value[rse_pkg::POLY_W-1:0];
            rse_pkg::CFG_GEN_LOW:    gen_low_cfg = value;
            rse_pkg::CFG_GEN_HIGH:   gen_high_cfg = value;
            default: ;
        endcase
    endtask

    task automatic set_code(logic [rse_pkg::POLY_W-1:0] poly,
                            logic [rse_pkg::COEF_REG_W-1:0] lo,
                            logic [rse_pkg::COEF_REG_W-1:0] hi);
        write_reg(rse_pkg::CFG_FIELD_POLY, rse_pkg::COEF_REG_W'(poly));
        write_reg(rse_pkg::CFG_GEN_LOW, lo);
        write_reg(rse_pkg::CFG_GEN_HIGH, hi);
    endtask

    task automatic drain;
        while (msg_queue.size() > 0 || s_tvalid || expected_code.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [rse_pkg::COEF_REG_W-1:0] rand_gen();
        return rse_pkg::COEF_REG_W'({$urandom, $urandom});
    endfunction

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default code: one-symbol block, then an exactly full block
        push_symbol(5'd31, 1'b1, 1'b0);
        for (int i = 0; i < rse_pkg::MSG_LEN; i++)
            push_symbol((i % 2) ? 5'd31 : 5'd0, i == rse_pkg::MSG_LEN - 1, 1'b0);
        // a block longer than the message length saturates the position
        for (int i = 0; i < rse_pkg::MSG_LEN + 3; i++)
            push_symbol(rse_pkg::SYM_W'($urandom), i == rse_pkg::MSG_LEN + 2, 1'b0);
        add_blocks(15, 1'b0);
        add_blocks(15, 1'b1);
        drain();

        set_code(6'd32, '0, '1);
        add_blocks(15, 1'b0);
        drain();

        set_code(6'd63, '1, '0);
        add_blocks(15, 1'b0);
        drain();

        // polynomial without the top term; spare index must be ignored
        set_code(rse_pkg::POLY_W'($urandom_range(31)), rand_gen(), rand_gen());
        write_reg(CFG_SPARE, rand_gen());
        push_symbol(5'd31, 1'b0, 1'b0);
        push_symbol(5'd31, 1'b1, 1'b0);
        add_blocks(15, 1'b0);
        drain();

        set_code(rse_pkg::POLY_W'($urandom_range(63, 32)), rand_gen(), rand_gen());
        add_blocks(15, 1'b0);
        drain();

        if (mismatches == 0 && expected_code.size() == 0) begin
            $display("reed_solomon_systematic_encoder_test passed");
        end else begin
            if (expected_code.size() > 0)
                $display("%0t: %0d expected transactions never arrived",
                         $time, expected_code.size());
            $display("reed_solomon_systematic_encoder_test failed");
        end
        $finish;
    end

endmodule
